// ===== src/m3i_pkg.sv =====
// m3i_pkg: types, widths and constant tables for the 3x3 matrix inverse
// no dependencies; imported by every module of the block

package m3i_pkg;

   // fixed-point format of entries and results
   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;

   // internal widths of the exact arithmetic
   localparam int PROD_W   = 2 * DATA_W;             // one 32x32 product
   localparam int ADJ_W    = PROD_W + 1;             // cofactor / adjugate entry
   localparam int ADJ_LO_W = ADJ_W - DATA_W;         // low slice of the split multiply
   localparam int LO_W     = DATA_W + ADJ_LO_W + 1;  // signed x unsigned partial product
   localparam int PDET_W   = DATA_W + ADJ_W;         // one term of the determinant
   localparam int DET_W    = PDET_W + 2;             // sum of three terms
   localparam int MAG_W    = DET_W;                  // magnitude of the determinant
   localparam int QBITS    = DATA_W;                 // quotient bits below saturation
   localparam int DEN_W    = MAG_W + 1;              // doubled determinant magnitude
   localparam int NUM_SH   = 2 * FRAC_BITS + 1;
   localparam int NUM_W    = ((ADJ_W + NUM_SH) > MAG_W) ? (ADJ_W + NUM_SH + 1) : (MAG_W + 1);
   localparam int REM_W    = (NUM_W > (DEN_W + QBITS)) ? NUM_W : (DEN_W + QBITS);

   // pipeline depth
   localparam int PRE_ST = 7;               // stages before the divider
   localparam int DIV_ST = QBITS + 1;       // range check plus one stage per quotient bit
   localparam int N_ST   = PRE_ST + DIV_ST + 1;

   // result constants
   localparam logic [DATA_W-1:0] ONE_FX = DATA_W'(1) << FRAC_BITS;
   localparam logic [DATA_W-1:0] FX_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] FX_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   // adjugate entry k = sign * (m[A]*m[B] - m[C]*m[D])
   localparam int COF_A [9] = '{4, 1, 1, 3, 0, 0, 3, 0, 0};
   localparam int COF_B [9] = '{8, 8, 5, 8, 8, 5, 7, 7, 4};
   localparam int COF_C [9] = '{5, 2, 2, 5, 2, 2, 4, 1, 1};
   localparam int COF_D [9] = '{7, 7, 4, 6, 6, 3, 6, 6, 3};
   localparam logic [8:0] COF_NEG = 9'b010101010;

   typedef struct packed {
      logic signed [DATA_W-1:0] m00;
      logic signed [DATA_W-1:0] m01;
      logic signed [DATA_W-1:0] m02;
      logic signed [DATA_W-1:0] m10;
      logic signed [DATA_W-1:0] m11;
      logic signed [DATA_W-1:0] m12;
      logic signed [DATA_W-1:0] m20;
      logic signed [DATA_W-1:0] m21;
      logic signed [DATA_W-1:0] m22;
   } m3i_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] r00;
      logic signed [DATA_W-1:0] r01;
      logic signed [DATA_W-1:0] r02;
      logic signed [DATA_W-1:0] r10;
      logic signed [DATA_W-1:0] r11;
      logic signed [DATA_W-1:0] r12;
      logic signed [DATA_W-1:0] r20;
      logic signed [DATA_W-1:0] r21;
      logic signed [DATA_W-1:0] r22;
      logic                     singular;
   } m3i_rsp_type;

   // per-item flags that ride alongside the divider
   typedef struct packed {
      logic [8:0] neg;
      logic       sing;
   } m3i_side_type;

endpackage

// ===== src/m3i_div.sv =====
// m3i_div: pipelined restoring divider, one quotient bit per stage
// depends on m3i_pkg; stage enables come from the top-level flow control

module m3i_div (
   input  logic                        clock,
   input  logic [m3i_pkg::DIV_ST-1:0]  en,
   input  logic [m3i_pkg::NUM_W-1:0]   num,
   input  logic [m3i_pkg::DEN_W-1:0]   den,
   output logic [m3i_pkg::QBITS-1:0]   quo,
   output logic                        ovf
);
   import m3i_pkg::*;

   logic [REM_W-1:0] rem_ff [DIV_ST];
   logic [REM_W-1:0] rem_in [DIV_ST];
   logic [REM_W-1:0] dsh_ff [DIV_ST];
   logic [REM_W-1:0] dsh_in [DIV_ST];
   logic [QBITS-1:0] quo_ff [DIV_ST];
   logic [QBITS-1:0] quo_in [DIV_ST];
   logic             ovf_ff [DIV_ST];
   logic             ovf_in [DIV_ST];

   // first stage: quotient must fit in QBITS, else saturate
   always_comb begin
      rem_in[0] = REM_W'(num);
      dsh_in[0] = REM_W'(den) << (QBITS - 1);
      quo_in[0] = '0;
      ovf_in[0] = REM_W'(num) >= (REM_W'(den) << QBITS);
   end

   // one compare and subtract per stage, remainder shifts up
   for (genvar k = 1; k < DIV_ST; k++) begin : g_step
      logic             ge;
      logic [REM_W-1:0] diff;
      always_comb begin
         ge        = rem_ff[k-1] >= dsh_ff[k-1];
         diff      = ge ? (rem_ff[k-1] - dsh_ff[k-1]) : rem_ff[k-1];
         rem_in[k] = diff << 1;
         dsh_in[k] = dsh_ff[k-1];
         quo_in[k] = {quo_ff[k-1][QBITS-2:0], ge};
         ovf_in[k] = ovf_ff[k-1];
      end
   end

   for (genvar k = 0; k < DIV_ST; k++) begin : g_reg
      always_ff @(posedge clock) begin
         if (en[k]) begin
            rem_ff[k] <= rem_in[k];
            dsh_ff[k] <= dsh_in[k];
            quo_ff[k] <= quo_in[k];
            ovf_ff[k] <= ovf_in[k];
         end
      end
   end

   assign quo = quo_ff[DIV_ST-1];
   assign ovf = ovf_ff[DIV_ST-1];

endmodule

// ===== src/matrix3x3_inverse.sv =====
// matrix3x3_inverse: top level, adjugate / determinant pipeline with saturation
// depends on m3i_pkg and m3i_div

// Inverts one 3x3 Q16.16 matrix per item as the adjugate divided by the
// determinant, exact internally, rounded to nearest with ties away from zero
// and saturated to the 32-bit range. A zero determinant returns the identity
// with singular set. A new item can be accepted every cycle while the
// pipeline is not backed up by a stalled output. Most of the pipeline is
// the divider, which produces one quotient bit per stage (32 stages plus a
// range check), after seven stages of multiply and sum.
// A stalled output holds only the stages behind it that are full; empty
// stages keep filling.

module matrix3x3_inverse (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  m3i_pkg::m3i_req_type  req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output m3i_pkg::m3i_rsp_type  rsp_data
);
   import m3i_pkg::*;

   // flow control: a stage moves when empty or when the next one moves
   logic [N_ST-1:0] v_ff;
   logic [N_ST-1:0] en;

   always_comb begin
      en[N_ST-1] = !v_ff[N_ST-1] || rsp_ready;
      for (int k = N_ST - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= req_valid;
         end
         for (int k = 1; k < N_ST; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = v_ff[N_ST-1];

   // input entries as an array
   logic signed [DATA_W-1:0] m [9];
   assign m[0] = req_data.m00;
   assign m[1] = req_data.m01;
   assign m[2] = req_data.m02;
   assign m[3] = req_data.m10;
   assign m[4] = req_data.m11;
   assign m[5] = req_data.m12;
   assign m[6] = req_data.m20;
   assign m[7] = req_data.m21;
   assign m[8] = req_data.m22;

   // stage 0: the eighteen cofactor products
   logic signed [PROD_W-1:0] pa_ff [9];
   logic signed [PROD_W-1:0] pb_ff [9];
   logic signed [DATA_W-1:0] mr0_ff [3];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int i = 0; i < 9; i++) begin
            pa_ff[i] <= PROD_W'(m[COF_A[i]]) * PROD_W'(m[COF_B[i]]);
            pb_ff[i] <= PROD_W'(m[COF_C[i]]) * PROD_W'(m[COF_D[i]]);
         end
         for (int i = 0; i < 3; i++) begin
            mr0_ff[i] <= m[i];
         end
      end
   end

   // stage 1: signed cofactors form the adjugate
   logic signed [ADJ_W-1:0]  adj1_ff [9];
   logic signed [DATA_W-1:0] mr1_ff [3];

   always_ff @(posedge clock) begin
      if (en[1]) begin
         for (int i = 0; i < 9; i++) begin
            adj1_ff[i] <= COF_NEG[i] ? (ADJ_W'(pb_ff[i]) - ADJ_W'(pa_ff[i]))
                                     : (ADJ_W'(pa_ff[i]) - ADJ_W'(pb_ff[i]));
         end
         mr1_ff <= mr0_ff;
      end
   end

   // stage 2: first-row terms split into two partial products each
   logic signed [LO_W-1:0]   lo_ff [3];
   logic signed [PROD_W-1:0] hi_ff [3];
   logic signed [ADJ_W-1:0]  adj2_ff [9];
   logic signed [LO_W-1:0]   lo_in [3];
   logic signed [PROD_W-1:0] hi_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         lo_in[i] = mr1_ff[i] * $signed({1'b0, adj1_ff[3*i][ADJ_LO_W-1:0]});
         hi_in[i] = mr1_ff[i] * $signed(adj1_ff[3*i][ADJ_W-1:ADJ_LO_W]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         lo_ff   <= lo_in;
         hi_ff   <= hi_in;
         adj2_ff <= adj1_ff;
      end
   end

   // stage 3: recombine partial products
   logic signed [PDET_W-1:0] prod_ff [3];
   logic signed [ADJ_W-1:0]  adj3_ff [9];

   always_ff @(posedge clock) begin
      if (en[3]) begin
         for (int i = 0; i < 3; i++) begin
            prod_ff[i] <= (PDET_W'(hi_ff[i]) <<< ADJ_LO_W) + PDET_W'(lo_ff[i]);
         end
         adj3_ff <= adj2_ff;
      end
   end

   // stage 4: determinant by expansion along the first row
   logic signed [DET_W-1:0] det_ff;
   logic signed [ADJ_W-1:0] adj4_ff [9];

   always_ff @(posedge clock) begin
      if (en[4]) begin
         det_ff  <= DET_W'(prod_ff[0]) + DET_W'(prod_ff[1]) + DET_W'(prod_ff[2]);
         adj4_ff <= adj3_ff;
      end
   end

   // stage 5: magnitudes and result signs
   logic [MAG_W-1:0] dmag_ff;
   logic [ADJ_W-1:0] amag_ff [9];
   m3i_side_type     side5_ff;

   always_ff @(posedge clock) begin
      if (en[5]) begin
         dmag_ff <= det_ff[DET_W-1] ? MAG_W'(-det_ff) : MAG_W'(det_ff);
         for (int i = 0; i < 9; i++) begin
            amag_ff[i]      <= adj4_ff[i][ADJ_W-1] ? ADJ_W'(-adj4_ff[i]) : ADJ_W'(adj4_ff[i]);
            side5_ff.neg[i] <= adj4_ff[i][ADJ_W-1] ^ det_ff[DET_W-1];
         end
         side5_ff.sing <= (det_ff == '0);
      end
   end

   // stage 6: rounding numerator 2*|adj|*2^(2F) + |det| over 2*|det|
   logic [NUM_W-1:0] num_ff [9];
   logic [DEN_W-1:0] den_ff;
   m3i_side_type     side6_ff;

   always_ff @(posedge clock) begin
      if (en[6]) begin
         for (int i = 0; i < 9; i++) begin
            num_ff[i] <= (NUM_W'(amag_ff[i]) << NUM_SH) + NUM_W'(dmag_ff);
         end
         den_ff   <= DEN_W'(dmag_ff) << 1;
         side6_ff <= side5_ff;
      end
   end

   // dividers, one per entry
   logic [QBITS-1:0] quo [9];
   logic             ovf [9];

   for (genvar i = 0; i < 9; i++) begin : g_div
      m3i_div u_div (
         .clock (clock),
         .en    (en[PRE_ST +: DIV_ST]),
         .num   (num_ff[i]),
         .den   (den_ff),
         .quo   (quo[i]),
         .ovf   (ovf[i])
      );
   end

   // flags travel beside the divider stages
   m3i_side_type side_ff [DIV_ST];

   always_ff @(posedge clock) begin
      if (en[PRE_ST]) begin
         side_ff[0] <= side6_ff;
      end
      for (int k = 1; k < DIV_ST; k++) begin
         if (en[PRE_ST+k]) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // final stage: saturate, apply sign, identity for a singular matrix
   logic [DATA_W-1:0] res [9];
   m3i_side_type      side_out;
   m3i_rsp_type       rsp_in;
   m3i_rsp_type       rsp_ff;

   assign side_out = side_ff[DIV_ST-1];

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         if (side_out.sing) begin
            res[i] = (i == 0 || i == 4 || i == 8) ? ONE_FX : '0;
         end else if (ovf[i]) begin
            res[i] = side_out.neg[i] ? FX_MIN : FX_MAX;
         end else if (side_out.neg[i]) begin
            res[i] = (quo[i] > FX_MIN) ? FX_MIN : DATA_W'(-quo[i]);
         end else begin
            res[i] = (quo[i] > FX_MAX) ? FX_MAX : quo[i];
         end
      end
      rsp_in.r00      = res[0];
      rsp_in.r01      = res[1];
      rsp_in.r02      = res[2];
      rsp_in.r10      = res[3];
      rsp_in.r11      = res[4];
      rsp_in.r12      = res[5];
      rsp_in.r20      = res[6];
      rsp_in.r21      = res[7];
      rsp_in.r22      = res[8];
      rsp_in.singular = side_out.sing;
   end

   always_ff @(posedge clock) begin
      if (en[N_ST-1]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== src/m3i_check.sv =====
// m3i_check: port-level checks for matrix3x3_inverse, bound to the top level
// depends on m3i_pkg

module m3i_check (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input m3i_pkg::m3i_rsp_type  rsp_data
);
   import m3i_pkg::*;

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // with the output empty nothing can hold back the input
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled while output is empty");

   // a singular matrix returns the identity
   a_identity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.singular |->
         rsp_data.r00 == ONE_FX && rsp_data.r11 == ONE_FX && rsp_data.r22 == ONE_FX &&
         rsp_data.r01 == '0 && rsp_data.r02 == '0 && rsp_data.r10 == '0 &&
         rsp_data.r12 == '0 && rsp_data.r20 == '0 && rsp_data.r21 == '0)
      else $error("singular item without identity result");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

endmodule

bind matrix3x3_inverse m3i_check u_m3i_check (.*);

// ===== verif/tb.sv =====
// tb: self-checking testbench for matrix3x3_inverse
// depends on m3i_pkg and the matrix3x3_inverse rtl

`timescale 1ns / 1ps

module tb;
   import m3i_pkg::*;

   localparam int LATENCY = 41;
   localparam int N_RAND  = 750;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   m3i_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   m3i_rsp_type rsp_data;

   m3i_req_type pending_mats[$];
   m3i_rsp_type inverse_q[$];
   int          n_errors = 0;
   bit          stim_done = 1'b0;
   bit          quiet = 1'b0;       // no idling in the last part of the run
   bit          hold_on = 1'b0;     // long receiver hold-off
   bit          req_taken = 1'b0;   // item accepted at the last rising edge
   int          send_gap = 0;
   int          recv_gap = 0;

   matrix3x3_inverse uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #6 clock = ~clock;

   // one inverse entry: cofactor * 2^(2F) / det, rounded half away, saturated
   function automatic logic [31:0] scaled_entry(logic signed [127:0] adj,
                                                logic signed [127:0] det);
      logic [255:0] mag_a, mag_d, num, quo;
      bit neg;
      neg   = (adj < 0) != (det < 0);
      mag_a = (adj < 0) ? 256'(-adj) : 256'(adj);
      mag_d = (det < 0) ? 256'(-det) : 256'(det);
      num   = mag_a << (2 * FRAC_BITS);
      quo   = ((num << 1) + mag_d) / (mag_d << 1);
      if (neg) begin
         if (quo > 256'h80000000) return 32'h80000000;
         return 32'(-quo[31:0]);
      end
      if (quo > 256'h7FFFFFFF) return 32'h7FFFFFFF;
      return quo[31:0];
   endfunction

   // expected inverse of one matrix
   function automatic m3i_rsp_type invert(m3i_req_type a);
      logic signed [127:0] m [9];
      logic signed [127:0] adj [9];
      logic signed [127:0] det;
      logic [31:0] r [9];
      m3i_rsp_type y;
      m = '{128'(a.m00), 128'(a.m01), 128'(a.m02), 128'(a.m10), 128'(a.m11),
            128'(a.m12), 128'(a.m20), 128'(a.m21), 128'(a.m22)};
      adj[0] =   m[4]*m[8] - m[5]*m[7];
      adj[1] = -(m[1]*m[8] - m[2]*m[7]);
      adj[2] =   m[1]*m[5] - m[2]*m[4];
      adj[3] = -(m[3]*m[8] - m[5]*m[6]);
      adj[4] =   m[0]*m[8] - m[2]*m[6];
      adj[5] = -(m[0]*m[5] - m[2]*m[3]);
      adj[6] =   m[3]*m[7] - m[4]*m[6];
      adj[7] = -(m[0]*m[7] - m[1]*m[6]);
      adj[8] =   m[0]*m[4] - m[1]*m[3];
      det = m[0]*adj[0] + m[1]*adj[3] + m[2]*adj[6];
      if (det == 0) begin
         foreach (r[k]) r[k] = (k % 4 == 0) ? ONE_FX : '0;
         y.singular = 1'b1;
      end else begin
         foreach (r[k]) r[k] = scaled_entry(adj[k], det);
         y.singular = 1'b0;
      end
      y.r00 = r[0]; y.r01 = r[1]; y.r02 = r[2];
      y.r10 = r[3]; y.r11 = r[4]; y.r12 = r[5];
      y.r20 = r[6]; y.r21 = r[7]; y.r22 = r[8];
      return y;
   endfunction

   function automatic logic [31:0] rand_entry();
      case ($urandom_range(0, 9))
         0: return 32'h80000000;
         1: return 32'h7FFFFFFF;
         2: return 32'($signed($urandom_range(0, 8)) - 4) << FRAC_BITS;
         3: return 32'($signed($urandom_range(0, 64)) - 32);
         4, 5: return 32'($signed($urandom_range(0, 32'h00080000)) - 32'sh00040000);
         default: return $urandom();
      endcase
   endfunction

   function automatic m3i_req_type mat(logic [31:0] a, b, c, d, e, f, g, h, i);
      return {a, b, c, d, e, f, g, h, i};
   endfunction

   // stimulus: directed matrices then random ones
   initial begin
      m3i_req_type t;
      logic [31:0] o;
      o = ONE_FX;
      pending_mats.push_back(mat(o, 0, 0, 0, o, 0, 0, 0, o));
      pending_mats.push_back('0);
      pending_mats.push_back({9{32'h80000000}});
      pending_mats.push_back({9{32'h7FFFFFFF}});
      pending_mats.push_back({9{32'hFFFFFFFF}});
      pending_mats.push_back(mat(1, 0, 0, 0, 1, 0, 0, 0, 1));
      pending_mats.push_back(mat(32'h80000000, 0, 0, 0, 32'h80000000, 0, 0, 0,
                                 32'h80000000));
      pending_mats.push_back(mat(32'h7FFFFFFF, 0, 0, 0, 32'h7FFFFFFF, 0, 0, 0,
                                 32'h7FFFFFFF));
      pending_mats.push_back(mat(o << 1, 0, 0, 0, o << 1, 0, 0, 0, o << 1));
      pending_mats.push_back(mat(3 * o, 0, 0, 0, 3 * o, 0, 0, 0, -3 * o));
      pending_mats.push_back(mat(2, 0, 0, 0, 2, 0, 0, 0, 2));
      pending_mats.push_back(mat(0, o, 0, o, 0, 0, 0, 0, o));
      pending_mats.push_back(mat(1, 2, 3, 4, 5, 6, 7, 8, 9));
      pending_mats.push_back(mat(o, o << 1, o, 0, o, 0, 0, 0, o));
      pending_mats.push_back(mat(32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                                 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                                 32'h80000000, 32'h7FFFFFFF, 32'h80000000));
      pending_mats.push_back(mat(32'h55555555, 32'hAAAAAAAA, 1, 32'hAAAAAAAA,
                                 32'h55555555, 2, 3, 4, 32'h55555555));
      for (int n = 0; n < N_RAND; n++) begin
         for (int k = 0; k < 9; k++) t[32*k +: 32] = rand_entry();
         // some singular matrices: duplicate a row or zero a column
         case ($urandom_range(0, 11))
            0: begin t.m20 = t.m00; t.m21 = t.m01; t.m22 = t.m02; end
            1: begin t.m01 = 0; t.m11 = 0; t.m21 = 0; end
            default: ;
         endcase
         pending_mats.push_back(t);
      end
   end

   // remember whether the offered item went in at the rising edge
   always @(posedge clock) begin
      if (reset) req_taken <= 1'b0;
      else req_taken <= req_valid && req_ready;
   end

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_mats.size() > 0 &&
                      (quiet || $urandom_range(0, 7) != 0)) begin
            req_data  <= pending_mats.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
            if (pending_mats.size() > 0 && !quiet) send_gap <= $urandom_range(1, 10);
            else if (pending_mats.size() == 0) stim_done <= 1'b1;
         end
      end
   end

   // long receiver hold-off while the sender keeps offering items
   initial begin
      wait (!reset && pending_mats.size() < 650);
      @(posedge clock);
      hold_on = 1'b1;
      repeat (120) @(posedge clock);
      hold_on = 1'b0;
   end

   // receiver ready, with bursts of stall and one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_on) begin
         rsp_ready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap <= recv_gap - 1;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         recv_gap <= $urandom_range(1, 10);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // predict on each accepted item
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) inverse_q.push_back(invert(req_data));
   end

   // compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      m3i_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (inverse_q.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_data);
            n_errors++;
         end else begin
            want = inverse_q.pop_front();
            if (want.r00 !== rsp_data.r00 || want.r01 !== rsp_data.r01 ||
                want.r02 !== rsp_data.r02 || want.r10 !== rsp_data.r10 ||
                want.r11 !== rsp_data.r11 || want.r12 !== rsp_data.r12 ||
                want.r20 !== rsp_data.r20 || want.r21 !== rsp_data.r21 ||
                want.r22 !== rsp_data.r22 || want.singular !== rsp_data.singular) begin
               $display("%0t: mismatch expected %h actual %h", $time, want, rsp_data);
               n_errors++;
            end
         end
      end
   end

   // sequencing: reset, quiet tail, drain
   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock) reset = 1'b0;
      wait (pending_mats.size() < 80);
      quiet = 1'b1;
      wait (stim_done && inverse_q.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      if (n_errors == 0 && inverse_q.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // run limit
   initial begin
      #5ms;
      $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/m3i_pkg.sv
src/m3i_div.sv
src/matrix3x3_inverse.sv
src/m3i_check.sv
verif/tb.sv
